// ----- design/nbgm_pkg.sv -----
// shared types, constants and the setup schedule of the narrow band grid marker
// no dependencies; imported by the top level and its checker
package nbgm_pkg;

	localparam int COORD_W     = 24;
	localparam int SPACING_W   = 23;
	localparam int INV_W       = 32;
	localparam int DIST_W      = 48;
	localparam int NPA_W       = 9;
	localparam int ID_W        = 20;
	localparam int CELL_W      = 24;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 48;
	localparam int MAX_RESULTS = 27;
	localparam int SETUP_STEPS = 20;
	localparam int STEP_W      = 5;
	localparam int OPA_W       = 25;
	localparam int OPB_W       = 32;
	localparam int PROD_W      = OPA_W + OPB_W;
	localparam int DIFF_W      = 34;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ORIGIN   = 3'd0,
		REG_SPACING  = 3'd1,
		REG_INVERSE  = 3'd2,
		REG_BAND_SQ  = 3'd3,
		REG_BAND     = 3'd4,
		REG_NPA      = 3'd5
	} reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SETUP,
		ST_WALK,
		ST_FLUSH
	} state_t;

	// what the shared multiplier is computing
	typedef enum logic [2:0] {
		OP_NONE,
		OP_NSQ,
		OP_SCALE,
		OP_BASE,
		OP_SQUARE,
		OP_ROW,
		OP_PLANE
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [1:0] axis;
		logic [1:0] k;
	} slot_t;

	typedef struct packed {
		op_t        op;
		logic [1:0] axis;
		logic [1:0] k;
		logic       neg;
		logic       ok;
	} tag_t;

	// multiplier issue order during setup
	function automatic slot_t issue_slot(input logic [STEP_W-1:0] step);
		slot_t s;
		s.op   = OP_NONE;
		s.axis = 2'd0;
		s.k    = 2'd0;
		case (step) inside
			5'd0: s.op = OP_NSQ;
			[5'd1:5'd3]: begin
				s.op   = OP_SCALE;
				s.axis = 2'(step - 5'd1);
			end
			[5'd4:5'd6]: begin
				s.op   = OP_BASE;
				s.axis = 2'(step - 5'd4);
			end
			5'd7:  begin s.op = OP_SQUARE; s.axis = 2'd0; s.k = 2'd0; end
			5'd8:  begin s.op = OP_SQUARE; s.axis = 2'd0; s.k = 2'd1; end
			5'd9:  begin s.op = OP_SQUARE; s.axis = 2'd0; s.k = 2'd2; end
			5'd10: begin s.op = OP_SQUARE; s.axis = 2'd1; s.k = 2'd0; end
			5'd11: begin s.op = OP_SQUARE; s.axis = 2'd1; s.k = 2'd1; end
			5'd12: begin s.op = OP_SQUARE; s.axis = 2'd1; s.k = 2'd2; end
			5'd13: begin s.op = OP_SQUARE; s.axis = 2'd2; s.k = 2'd0; end
			5'd14: begin s.op = OP_SQUARE; s.axis = 2'd2; s.k = 2'd1; end
			5'd15: begin s.op = OP_SQUARE; s.axis = 2'd2; s.k = 2'd2; end
			5'd16: s.op = OP_ROW;
			5'd17: s.op = OP_PLANE;
			default: s.op = OP_NONE;
		endcase
		return s;
	endfunction

endpackage

// ----- design/narrow_band_grid_marker.sv -----
// narrow band grid marker: maps a point to its grid cell and lists nearby cells
// depends on nbgm_pkg; one shared multiplier under a step sequencer
//
//  channel   signals                                     handshake
//  -------   -----------------------------------------   -----------------------------
//  item in   coord_x coord_y coord_z point_id            start & !busy at clock edge
//  result    cell_index owner_id last_cell               result_strobe, one cycle each
//  config    cfg_index cfg_data                          cfg_valid & cfg_ready
//
// an item keeps busy high through setup, then visits each candidate cell of the clamped
// box (1 to 27) in turn and takes a closing step; a box clamped away ends after setup
// setup issues 18 products to the one multiplier, then drains its two register stages
// a hit is held until the next hit or the closing cycle releases it, so the final one
// can carry last_cell; a released result shows in the next cycle; the receiver cannot stall
// arst_n clears the sequencer and loads the register defaults
module narrow_band_grid_marker
	import nbgm_pkg::*;
#(
	parameter int MAX_CELLS_PER_AXIS = 256
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic signed [COORD_W-1:0]    coord_x,
	input  logic signed [COORD_W-1:0]    coord_y,
	input  logic signed [COORD_W-1:0]    coord_z,
	input  logic [ID_W-1:0]              point_id,
	output logic                         result_strobe,
	output logic [CELL_W-1:0]            cell_index,
	output logic [ID_W-1:0]              owner_id,
	output logic                         last_cell,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [CFG_IDX_W-1:0]         cfg_index,
	input  logic [CFG_DATA_W-1:0]        cfg_data
);

	localparam int IW = (MAX_CELLS_PER_AXIS > 2) ? $clog2(MAX_CELLS_PER_AXIS) : 1;
	localparam logic [NPA_W-1:0] MAXN = NPA_W'(MAX_CELLS_PER_AXIS);

	// configuration
	logic signed [COORD_W-1:0] origin_q;
	logic [SPACING_W-1:0]      spacing_q;
	logic [INV_W-1:0]          inverse_q;
	logic [DIST_W-1:0]         band_sq_q;
	logic                      band_q;
	logic [NPA_W-1:0]          npa_q;

	// control
	state_t            state_q, state_d;
	logic [STEP_W-1:0] step_q;
	logic [1:0]        kx_q, ky_q, kz_q;
	logic              pend_v_q;
	logic              strobe_q, last_q;
	tag_t              tag_s1, tag_s2;

	// datapath
	logic signed [COORD_W-1:0] s_q [0:2];
	logic [ID_W-1:0]           id_q;
	logic [OPA_W-1:0]          op_a_s1;
	logic [OPB_W-1:0]          op_b_s1;
	logic [PROD_W-1:0]         prod_s2;
	logic [16:0]               nsq_q;
	logic [IW-1:0]             lo_q [0:2];
	logic [1:0]                span_q [0:2];
	logic [2:0]                empty_q;
	logic signed [DIFF_W-1:0]  d0_q [0:2];
	logic [DIST_W-1:0]         sq_q [0:2][0:2];
	logic                      ok_q [0:2][0:2];
	logic [CELL_W-1:0]         idx_q, xbase_q, ybase_q, pend_idx_q;
	logic [CELL_W-1:0]         cell_q;
	logic [ID_W-1:0]           owner_q;

	logic              accept;
	logic [NPA_W-1:0]  n_eff;
	slot_t             slot;
	tag_t              tag_d;
	logic [OPA_W-1:0]  op_a_d;
	logic [OPB_W-1:0]  op_b_d;

	assign accept    = start && (state_q == ST_IDLE);
	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;

	assign n_eff = (npa_q < NPA_W'(2)) ? NPA_W'(2) : ((npa_q > MAXN) ? MAXN : npa_q);

	// ---------------- multiplier issue ----------------
	logic signed [COORD_W:0]  sc_d;
	logic [COORD_W:0]         sc_mag;
	logic signed [DIFF_W-1:0] sq_d;
	logic [DIFF_W-1:0]        sq_mag;
	logic [DIFF_W-1:0]        koff;

	always_comb begin
		slot = (state_q == ST_SETUP) ? issue_slot(step_q) : slot_t'{OP_NONE, 2'd0, 2'd0};
		sc_d   = {s_q[slot.axis][COORD_W-1], s_q[slot.axis]} - {origin_q[COORD_W-1], origin_q};
		sc_mag = sc_d[COORD_W] ? (COORD_W+1)'(-sc_d) : (COORD_W+1)'(sc_d);
		case (slot.k)
			2'd1:    koff = DIFF_W'(spacing_q);
			2'd2:    koff = DIFF_W'({spacing_q, 1'b0});
			default: koff = '0;
		endcase
		sq_d   = d0_q[slot.axis] + signed'(koff);
		sq_mag = sq_d[DIFF_W-1] ? DIFF_W'(-sq_d) : sq_d;

		tag_d.op   = slot.op;
		tag_d.axis = slot.axis;
		tag_d.k    = slot.k;
		tag_d.neg  = sc_d[COORD_W];
		tag_d.ok   = (sq_mag[DIFF_W-1:COORD_W] == '0);
		op_a_d     = '0;
		op_b_d     = '0;
		case (slot.op)
			OP_NSQ: begin
				op_a_d = OPA_W'(n_eff);
				op_b_d = OPB_W'(n_eff);
			end
			OP_SCALE: begin
				op_a_d = sc_mag;
				op_b_d = inverse_q;
			end
			OP_BASE: begin
				op_a_d = OPA_W'(lo_q[slot.axis]);
				op_b_d = OPB_W'(spacing_q);
			end
			OP_SQUARE: begin
				op_a_d = OPA_W'(sq_mag[COORD_W-1:0]);
				op_b_d = OPB_W'(sq_mag[COORD_W-1:0]);
			end
			OP_ROW: begin
				op_a_d = OPA_W'(n_eff);
				op_b_d = OPB_W'(lo_q[1]);
			end
			OP_PLANE: begin
				op_a_d = OPA_W'(nsq_q);
				op_b_d = OPB_W'(lo_q[2]);
			end
			default: begin
				op_a_d = '0;
				op_b_d = '0;
			end
		endcase
	end

	// ---------------- writeback of scaled coordinate ----------------
	logic [PROD_W:0]          rnd;
	logic [COORD_W:0]         q_mag;
	logic signed [26:0]       g, lo_raw, hi_raw, n1, lo_c, hi_c, span_w;
	logic                     box_empty;
	logic signed [DIFF_W-1:0] base_diff;

	always_comb begin
		rnd       = {1'b0, prod_s2} + (PROD_W+1)'(64'h8000_0000);
		q_mag     = rnd[56:32];
		g         = tag_s2.neg ? -signed'({2'b00, q_mag}) : signed'({2'b00, q_mag});
		lo_raw    = g - signed'(27'(band_q));
		hi_raw    = g + signed'(27'(band_q));
		n1        = signed'(27'(n_eff - NPA_W'(1)));
		box_empty = (hi_raw < 0) || (lo_raw > n1);
		lo_c      = (lo_raw < 0) ? 27'sd0 : lo_raw;
		hi_c      = (hi_raw > n1) ? n1 : hi_raw;
		span_w    = hi_c - lo_c;
		// centre of the lowest cell minus the point
		base_diff = DIFF_W'(origin_q) + signed'({3'b000, prod_s2[30:0]})
			- DIFF_W'(s_q[tag_s2.axis]);
	end

	// ---------------- walk over the box ----------------
	logic [DIST_W+1:0] dist_sum;
	logic              hit, kx_end, ky_end, kz_end, last_pos;
	logic              emit, emit_last;

	always_comb begin
		dist_sum = (DIST_W+2)'(sq_q[0][kx_q]) + (DIST_W+2)'(sq_q[1][ky_q])
			+ (DIST_W+2)'(sq_q[2][kz_q]);
		hit = ok_q[0][kx_q] && ok_q[1][ky_q] && ok_q[2][kz_q]
			&& (dist_sum <= (DIST_W+2)'(band_sq_q));
		kx_end   = (kx_q == span_q[0]);
		ky_end   = (ky_q == span_q[1]);
		kz_end   = (kz_q == span_q[2]);
		last_pos = kx_end && ky_end && kz_end;
	end

	always_comb begin
		state_d   = state_q;
		emit      = 1'b0;
		emit_last = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (start) state_d = ST_SETUP;
			end
			ST_SETUP: begin
				if (step_q == STEP_W'(SETUP_STEPS - 1))
					state_d = (|empty_q) ? ST_IDLE : ST_WALK;
			end
			ST_WALK: begin
				// a newer hit releases the held one
				emit = hit && pend_v_q;
				if (last_pos) state_d = ST_FLUSH;
			end
			ST_FLUSH: begin
				emit      = pend_v_q;
				emit_last = 1'b1;
				state_d   = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// ---------------- control registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_q  <= '0;
			spacing_q <= SPACING_W'(65536);
			inverse_q <= INV_W'(65536);
			band_sq_q <= '0;
			band_q    <= 1'b1;
			npa_q     <= NPA_W'(256);
			state_q   <= ST_IDLE;
			step_q    <= '0;
			kx_q      <= '0;
			ky_q      <= '0;
			kz_q      <= '0;
			pend_v_q  <= 1'b0;
			strobe_q  <= 1'b0;
			last_q    <= 1'b0;
			tag_s1    <= '{OP_NONE, 2'd0, 2'd0, 1'b0, 1'b0};
			tag_s2    <= '{OP_NONE, 2'd0, 2'd0, 1'b0, 1'b0};
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_ORIGIN:  origin_q  <= cfg_data[COORD_W-1:0];
					REG_SPACING: spacing_q <= cfg_data[SPACING_W-1:0];
					REG_INVERSE: inverse_q <= cfg_data[INV_W-1:0];
					REG_BAND_SQ: band_sq_q <= cfg_data[DIST_W-1:0];
					REG_BAND:    band_q    <= cfg_data[0];
					REG_NPA:     npa_q     <= cfg_data[NPA_W-1:0];
					default: ;
				endcase
			end
			state_q  <= state_d;
			tag_s1   <= tag_d;
			tag_s2   <= tag_s1;
			strobe_q <= emit;
			last_q   <= emit && emit_last;
			if (accept) begin
				step_q   <= '0;
				kx_q     <= '0;
				ky_q     <= '0;
				kz_q     <= '0;
				pend_v_q <= 1'b0;
			end else if (state_q == ST_SETUP) begin
				step_q <= step_q + STEP_W'(1);
			end else if (state_q == ST_WALK) begin
				if (hit) pend_v_q <= 1'b1;
				if (!kz_end) begin
					kz_q <= kz_q + 2'd1;
				end else begin
					kz_q <= '0;
					if (!ky_end) begin
						ky_q <= ky_q + 2'd1;
					end else begin
						ky_q <= '0;
						kx_q <= kx_q + 2'd1;
					end
				end
			end else if (state_q == ST_FLUSH) begin
				pend_v_q <= 1'b0;
			end
		end
	end

	// ---------------- datapath registers ----------------
	always_ff @(posedge clk) begin
		if (accept) begin
			s_q[0] <= coord_x;
			s_q[1] <= coord_y;
			s_q[2] <= coord_z;
			id_q   <= point_id;
		end
		op_a_s1 <= op_a_d;
		op_b_s1 <= op_b_d;
		prod_s2 <= PROD_W'(op_a_s1) * PROD_W'(op_b_s1);

		case (tag_s2.op)
			OP_NSQ: nsq_q <= prod_s2[16:0];
			OP_SCALE: begin
				lo_q[tag_s2.axis]    <= lo_c[IW-1:0];
				span_q[tag_s2.axis]  <= span_w[1:0];
				empty_q[tag_s2.axis] <= box_empty;
				if (tag_s2.axis == 2'd0) begin
					idx_q   <= CELL_W'(lo_c[IW-1:0]);
					xbase_q <= CELL_W'(lo_c[IW-1:0]);
					ybase_q <= CELL_W'(lo_c[IW-1:0]);
				end
			end
			OP_BASE: d0_q[tag_s2.axis] <= base_diff;
			OP_SQUARE: begin
				sq_q[tag_s2.axis][tag_s2.k] <= prod_s2[DIST_W-1:0];
				ok_q[tag_s2.axis][tag_s2.k] <= tag_s2.ok;
			end
			OP_ROW, OP_PLANE: begin
				idx_q   <= idx_q + prod_s2[CELL_W-1:0];
				xbase_q <= xbase_q + prod_s2[CELL_W-1:0];
				ybase_q <= ybase_q + prod_s2[CELL_W-1:0];
			end
			default: ;
		endcase

		if (state_q == ST_WALK) begin
			if (hit) pend_idx_q <= idx_q;
			// z steps by n*n, y by n, x by one
			if (!kz_end) begin
				idx_q <= idx_q + CELL_W'(nsq_q);
			end else if (!ky_end) begin
				ybase_q <= ybase_q + CELL_W'(n_eff);
				idx_q   <= ybase_q + CELL_W'(n_eff);
			end else begin
				xbase_q <= xbase_q + CELL_W'(1);
				ybase_q <= xbase_q + CELL_W'(1);
				idx_q   <= xbase_q + CELL_W'(1);
			end
		end

		if (emit) begin
			cell_q  <= pend_idx_q;
			owner_q <= id_q;
		end
	end

	assign result_strobe = strobe_q;
	assign cell_index    = cell_q;
	assign owner_id      = owner_q;
	assign last_cell     = last_q;

endmodule

// ----- design/nbgm_checker.sv -----
// port-level checks for the narrow band grid marker, bound to the top level
// depends on nbgm_pkg
module nbgm_port_checks
	import nbgm_pkg::*;
(
	input logic                      clk,
	input logic                      arst_n,
	input logic                      start,
	input logic                      busy,
	input logic signed [COORD_W-1:0] coord_x,
	input logic signed [COORD_W-1:0] coord_y,
	input logic signed [COORD_W-1:0] coord_z,
	input logic [ID_W-1:0]           point_id,
	input logic                      result_strobe,
	input logic [CELL_W-1:0]         cell_index,
	input logic [ID_W-1:0]           owner_id,
	input logic                      last_cell,
	input logic                      cfg_valid,
	input logic                      cfg_ready,
	input logic [CFG_IDX_W-1:0]      cfg_index,
	input logic [CFG_DATA_W-1:0]     cfg_data
);

	logic [4:0] count_q;

	// results seen since the last accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (start && !busy) begin
			count_q <= '0;
		end else if (result_strobe && (count_q != 5'd31)) begin
			count_q <= count_q + 5'd1;
		end
	end

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy not raised after an accepted item");

	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> !result_strobe)
		else $error("result right after an accepted item");

	a_result_in_item: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> $past(busy))
		else $error("result without an item in flight");

	a_last_ends_item: assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && last_cell) |-> (!busy ##1 !result_strobe))
		else $error("item still running after its last result");

	a_result_count: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> (count_q < 5'(MAX_RESULTS)))
		else $error("too many results for one item");

endmodule

bind narrow_band_grid_marker nbgm_port_checks u_nbgm_port_checks (.*);
